// ----- rtl/ffha_pkg.sv -----
// ffha_pkg: shared constants, codes and control types of the first-fit heap allocator
// used by ffha_ctrl, ffha_dpath and first_fit_heap_allocator; no dependencies
`timescale 1ns / 1ps

package ffha_pkg;

  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned GAP_BYTES    = 4;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned SIZE_W = 24;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned REG_W  = 2;

  localparam logic [ADDR_W-1:0] HDR_ADD     = ADDR_W'(HEADER_BYTES);
  localparam logic [ADDR_W-1:0] HDR_GAP_ADD = ADDR_W'(HEADER_BYTES + GAP_BYTES);
  localparam logic [CNT_W-1:0]  CNT_MAX     = CNT_W'(MAX_BLOCKS);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [REG_W-1:0] REG_HEAP_START = 2'd0;
  localparam logic [REG_W-1:0] REG_HEAP_LIMIT = 2'd1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_OOM     = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic zero;
    logic hit;
    logic miss;
  } cmd_t;

  typedef struct packed {
    logic zero_req;
    logic hit;
    logic exhausted;
  } stat_t;

endpackage

// ----- rtl/ffha_ctrl.sv -----
// ffha_ctrl: sequencer of the allocator; starts an item, steps the block scan
// and picks how the item ends; depends on ffha_pkg
`timescale 1ns / 1ps

module ffha_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  output ffha_pkg::cmd_t cmd_o,
  input  ffha_pkg::stat_t stat_i
);
  import ffha_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.zero_req) begin
          cmd_o.zero = 1'b1;
          state_d    = S_IDLE;
        end else if (stat_i.hit) begin
          cmd_o.hit = 1'b1;
          state_d   = S_IDLE;
        end else if (stat_i.exhausted) begin
          cmd_o.miss = 1'b1;
          state_d    = S_IDLE;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ----- rtl/ffha_dpath.sv -----
// ffha_dpath: block table memories, in-use bits, bump pointer, byte count and result
// registers of the allocator; depends on ffha_pkg
`timescale 1ns / 1ps

module ffha_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ffha_pkg::REG_W-1:0]    cfg_idx_i,
  input  logic [ffha_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input  logic                          mode_i,
  input  logic [ffha_pkg::SIZE_W-1:0]   request_size_i,
  input  logic [ffha_pkg::ADDR_W-1:0]   free_address_i,
  input  ffha_pkg::cmd_t                cmd_i,
  output ffha_pkg::stat_t               stat_o,
  output logic                          done_o,
  output logic [ffha_pkg::ADDR_W-1:0]   payload_address_o,
  output logic [ffha_pkg::STAT_W-1:0]   status_o,
  output logic [ffha_pkg::ADDR_W-1:0]   used_bytes_o
);
  import ffha_pkg::*;

  logic [ADDR_W-1:0] mem_start [MAX_BLOCKS];
  logic [SIZE_W-1:0] mem_size  [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] in_use_q, in_use_d;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] bump_q, bump_d;
  logic [ADDR_W-1:0] limit_q, limit_d;
  logic [ADDR_W-1:0] used_q, used_d;

  logic              mode_q;
  logic [SIZE_W-1:0] req_q;
  logic [ADDR_W-1:0] addr_q;

  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]  chk_idx_q;
  logic [ADDR_W-1:0] start_rd_q;
  logic [SIZE_W-1:0] size_rd_q;

  logic              done_q, done_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  status_e           res_stat_q, res_stat_d;

  logic              issue;
  logic              alloc_match, free_match;
  logic [ADDR_W:0]   end_addr;
  logic              table_full, heap_full, append_we;
  logic [ADDR_W-1:0] req_ext;

  assign req_ext = {{(ADDR_W-SIZE_W){1'b0}}, req_q};
  assign issue   = cmd_i.scan && (idx_q < count_q);

  assign alloc_match = !in_use_q[chk_idx_q] && (size_rd_q >= req_q);
  assign free_match  = ((start_rd_q + HDR_ADD) == addr_q);

  assign stat_o.zero_req  = (mode_q == MODE_ALLOC) && (req_q == '0);
  assign stat_o.hit       = chk_vld_q && ((mode_q == MODE_FREE) ? free_match : alloc_match);
  assign stat_o.exhausted = !chk_vld_q && (idx_q == count_q);

  assign end_addr   = {1'b0, bump_q} + {1'b0, req_ext} + {1'b0, HDR_ADD};
  assign table_full = (count_q >= CNT_MAX);
  assign heap_full  = (end_addr >= {1'b0, limit_q});
  assign append_we  = cmd_i.miss && (mode_q == MODE_ALLOC) && !table_full && !heap_full;

  // table memories
  always_ff @(posedge clk_i) begin
    if (append_we) begin
      mem_start[count_q[IDX_W-1:0]] <= bump_q;
      mem_size[count_q[IDX_W-1:0]]  <= req_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      start_rd_q <= mem_start[idx_q[IDX_W-1:0]];
      size_rd_q  <= mem_size[idx_q[IDX_W-1:0]];
      chk_idx_q  <= idx_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      req_q  <= request_size_i;
      addr_q <= free_address_i;
    end
    res_addr_q <= res_addr_d;
    res_stat_q <= res_stat_d;
  end

  always_comb begin
    idx_d      = idx_q;
    chk_vld_d  = chk_vld_q;
    in_use_d   = in_use_q;
    count_d    = count_q;
    bump_d     = bump_q;
    limit_d    = limit_q;
    used_d     = used_q;
    done_d     = 1'b0;
    res_addr_d = res_addr_q;
    res_stat_d = res_stat_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HEAP_START: begin
          if (count_q == '0) begin
            bump_d = cfg_wdata_i;
          end
        end
        REG_HEAP_LIMIT: limit_d = cfg_wdata_i;
        default: ;
      endcase
    end

    if (cmd_i.load) begin
      idx_d     = '0;
      chk_vld_d = 1'b0;
    end

    if (cmd_i.scan) begin
      chk_vld_d = issue;
      if (issue) begin
        idx_d = idx_q + CNT_W'(1);
      end
    end

    if (cmd_i.zero) begin
      done_d     = 1'b1;
      res_addr_d = '0;
      res_stat_d = ST_ZERO;
    end

    if (cmd_i.hit) begin
      done_d     = 1'b1;
      res_stat_d = ST_OK;
      if (mode_q == MODE_FREE) begin
        in_use_d[chk_idx_q] = 1'b0;
        used_d     = used_q - ({{(ADDR_W-SIZE_W){1'b0}}, size_rd_q} + HDR_ADD);
        res_addr_d = '0;
      end else begin
        in_use_d[chk_idx_q] = 1'b1;
        used_d     = used_q + req_ext + HDR_ADD;
        res_addr_d = start_rd_q + HDR_ADD;
      end
    end

    if (cmd_i.miss) begin
      done_d     = 1'b1;
      res_addr_d = '0;
      if (mode_q == MODE_FREE) begin
        res_stat_d = ST_UNKNOWN;
      end else if (append_we) begin
        in_use_d[count_q[IDX_W-1:0]] = 1'b1;
        count_d    = count_q + CNT_W'(1);
        bump_d     = bump_q + req_ext + HDR_GAP_ADD;
        used_d     = used_q + req_ext + HDR_GAP_ADD;
        res_addr_d = bump_q + HDR_ADD;
        res_stat_d = ST_OK;
      end else begin
        res_stat_d = ST_OOM;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      chk_vld_q <= 1'b0;
      in_use_q  <= '0;
      count_q   <= '0;
      bump_q    <= '0;
      limit_q   <= '0;
      used_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      chk_vld_q <= chk_vld_d;
      in_use_q  <= in_use_d;
      count_q   <= count_d;
      bump_q    <= bump_d;
      limit_q   <= limit_d;
      used_q    <= used_d;
      done_q    <= done_d;
    end
  end

  assign done_o            = done_q;
  assign payload_address_o = res_addr_q;
  assign status_o          = res_stat_q;
  assign used_bytes_o      = used_q;

endmodule

// ----- rtl/first_fit_heap_allocator.sv -----
// first_fit_heap_allocator: top level, joins the sequencer and the datapath
// depends on ffha_pkg, ffha_ctrl and ffha_dpath
`timescale 1ns / 1ps

// usage
//   command channel: an item (mode_i, request_size_i, free_address_i) is taken
//   at a clock edge with start high and busy low. mode 0 allocates, mode 1 frees.
//   result channel: done_o is high for one cycle with payload_address_o,
//   status_o and used_bytes_o; there is no back-pressure, results are never held.
//   config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i at once (0 heap
//   start if no blocks, 1 heap limit, 2-3 ignored); write only while busy is low.
//   timing: the block table is scanned one entry per cycle through the
//   registered table read port, so busy stays high until a zero size, a hit or
//   the end of the table ends the item. done_o rises in the same cycle
//   as busy falls; a new start may be given in that cycle.
//   one item is in work at a time.
//   reset: no blocks, all blocks free, bump pointer and heap limit at 0,
//   used-byte count at 0; the table contents need no clearing.

module first_fit_heap_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ffha_pkg::REG_W-1:0]  cfg_idx_i,
  input  logic [ffha_pkg::ADDR_W-1:0] cfg_wdata_i,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode_i,
  input  logic [ffha_pkg::SIZE_W-1:0] request_size_i,
  input  logic [ffha_pkg::ADDR_W-1:0] free_address_i,
  output logic                        done_o,
  output logic [ffha_pkg::ADDR_W-1:0] payload_address_o,
  output logic [ffha_pkg::STAT_W-1:0] status_o,
  output logic [ffha_pkg::ADDR_W-1:0] used_bytes_o
);
  import ffha_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ffha_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  ffha_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .mode_i            (mode_i),
    .request_size_i    (request_size_i),
    .free_address_i    (free_address_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .done_o            (done_o),
    .payload_address_o (payload_address_o),
    .status_o          (status_o),
    .used_bytes_o      (used_bytes_o)
  );

endmodule
